// ===== hdl/lkv_pkg.sv =====
`default_nettype none

package lkv_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // token that walks the cell row looking for the key
  typedef struct packed {
    logic             vld;
    logic             hit;
    logic [VAL_W-1:0] value;
  } scan_t;

  // request and commit controls broadcast to every cell
  typedef struct packed {
    logic             commit;
    logic             hit;
    logic             put;
    logic             evict;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/lkv_cell.sv =====
`default_nettype none

module lkv_cell
  import lkv_pkg::*;
#(
  parameter int ENTRIES = 16,
  parameter int IDX     = 0
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire scan_t                            scan_in,
  input  wire logic [$clog2(ENTRIES)-1:0]       scan_rank_in,
  output scan_t                                 scan_out,
  output logic [$clog2(ENTRIES)-1:0]            scan_rank_out,
  input  wire cmd_t                             cmd,
  input  wire logic [$clog2(ENTRIES)-1:0]       hit_rank,
  input  wire logic [$clog2(ENTRIES+1)-1:0]     occ
);

  localparam int RANK_W = $clog2(ENTRIES);
  localparam int OCC_W  = $clog2(ENTRIES + 1);

  logic              valid;
  logic [KEY_W-1:0]  key;
  logic [VAL_W-1:0]  value;
  logic [RANK_W-1:0] rank;

  scan_t             scan_next;
  logic [RANK_W-1:0] scan_rank_next;
  logic              own;
  logic [OCC_W-1:0]  occ_m1;
  logic              target;

  assign own    = valid && (key == cmd.key);
  assign occ_m1 = occ - OCC_W'(1);

  // the least recent entry always holds rank occupancy-1; a free slot is index occupancy
  assign target = cmd.evict ? (valid && (rank == occ_m1[RANK_W-1:0]))
                            : (occ == OCC_W'(IDX));

  always_comb begin
    scan_next      = scan_in;
    scan_rank_next = scan_rank_in;
    if (scan_in.vld && !scan_in.hit && own) begin
      scan_next.hit   = 1'b1;
      scan_next.value = value;
      scan_rank_next  = rank;
    end
  end

  always_ff @(posedge clk) begin
    scan_out      <= scan_next;
    scan_rank_out <= scan_rank_next;
    if (rst) begin
      scan_out.vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (cmd.hit) begin
        if (own) begin
          rank <= '0;
          if (cmd.put) begin
            value <= cmd.value;
          end
        end else if (valid && (rank < hit_rank)) begin
          rank <= rank + RANK_W'(1);
        end
      end else if (cmd.put) begin
        if (target) begin
          valid <= 1'b1;
          key   <= cmd.key;
          value <= cmd.value;
          rank  <= '0;
        end else if (valid) begin
          rank <= rank + RANK_W'(1);
        end
      end
    end
    if (rst) begin
      valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lru_key_value_cache.sv =====
// Fully associative key-value cache with least-recently-used replacement.
// Input channel (in_valid/in_ready) carries one item: action (0 get, 1 put),
// key and value. Output channel (out_valid/out_ready) returns one item per
// input: found, and read_value (stored value on a get hit, else zero).
// Capacity is set through cfg_wr_en/cfg_wr_data; the user must write it only
// while the cache is idle, and the block itself does not enforce this. Zero
// acts as one, and values above ENTRIES act as ENTRIES. The entries form a
// row of cells. A lookup token walks the row one cell per cycle, then a
// single commit cycle updates all cells at once. One item is in flight at a
// time; the next is accepted once the last has walked the row and committed.
// A finished result waits in the output register; the next item is accepted
// while it waits, and its commit holds until the receiver takes the result,
// so a stalled receiver stalls the cache without loss.
// Reset (rst, synchronous) empties every entry and sets capacity to 16.
`default_nettype none

module lru_key_value_cache
  import lkv_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    action,
  input  wire logic signed [KEY_W-1:0] key,
  input  wire logic signed [VAL_W-1:0] value,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         found,
  output logic signed [VAL_W-1:0]      read_value,
  input  wire logic                    cfg_wr_en,
  input  wire logic [CAP_W-1:0]        cfg_wr_data
);

  localparam int RANK_W = $clog2(ENTRIES);
  localparam int OCC_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [CAP_W-1:0]  capacity;
  logic [OCC_W-1:0]  occ;
  logic              start;
  logic              req_put;
  logic [KEY_W-1:0]  req_key;
  logic [VAL_W-1:0]  req_value;
  logic              res_hit;
  logic [RANK_W-1:0] res_rank;
  logic [VAL_W-1:0]  res_value;
  logic              evict;
  logic              commit;
  logic              in_accept;
  cmd_t              cmd;

  scan_t             scan_link [ENTRIES+1];
  logic [RANK_W-1:0] rank_link [ENTRIES+1];

  assign in_ready  = (state == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign commit    = (state == ST_DONE) && (!out_valid || out_ready);

  // full when occupancy reaches max(capacity, 1) or the whole row
  assign evict = (CMP_W'(occ) >= CMP_W'(ENTRIES)) ||
                 ((CMP_W'(occ) >= CMP_W'(capacity)) && (occ != '0));

  always_comb begin
    cmd.commit = commit;
    cmd.hit    = res_hit;
    cmd.put    = req_put;
    cmd.evict  = evict;
    cmd.key    = req_key;
    cmd.value  = req_value;
  end

  assign scan_link[0] = scan_t'{vld: start, hit: 1'b0, value: '0};
  assign rank_link[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lkv_cell #(
      .ENTRIES(ENTRIES),
      .IDX    (i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .scan_in      (scan_link[i]),
      .scan_rank_in (rank_link[i]),
      .scan_out     (scan_link[i+1]),
      .scan_rank_out(rank_link[i+1]),
      .cmd          (cmd),
      .hit_rank     (res_rank),
      .occ          (occ)
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_link[ENTRIES].vld) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (commit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    state <= state_next;
    start <= in_accept;
    if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
    if (in_accept) begin
      req_put   <= action;
      req_key   <= key;
      req_value <= value;
    end
    if ((state == ST_SCAN) && scan_link[ENTRIES].vld) begin
      res_hit   <= scan_link[ENTRIES].hit;
      res_rank  <= rank_link[ENTRIES];
      res_value <= scan_link[ENTRIES].value;
    end
    if (commit && !res_hit && req_put && !evict) begin
      occ <= occ + OCC_W'(1);
    end
    if (commit) begin
      out_valid  <= 1'b1;
      found      <= res_hit;
      read_value <= (res_hit && !req_put) ? res_value : '0;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (rst) begin
      state     <= ST_IDLE;
      start     <= 1'b0;
      capacity  <= CAP_RESET;
      occ       <= '0;
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lkv_checker.sv =====
`default_nettype none

module lkv_checker
  import lkv_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic                    found,
  input wire logic signed [VAL_W-1:0] read_value
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(found) && $stable(read_value))
    else $error("result changed while stalled");

  // a miss never carries data
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> read_value == '0)
    else $error("miss with nonzero value");

  // one item in flight: busy right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while busy");

  // a new result appears only after the cache was busy
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result without an item in flight");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (.*);

`default_nettype wire
